### design/ohlc_pkg.sv
// Shared types and constants for the OHLC candle aggregator.
package ohlc_pkg;

    localparam int TimeW   = 32;
    localparam int PriceW  = 32;
    localparam int SizeW   = 32;
    localparam int VolW    = 48;
    localparam int FrameW  = 17;
    localparam int StepW   = 5;

    localparam logic [FrameW-1:0] FrameReset = FrameW'(60);
    localparam logic [VolW-1:0]   VolMax     = {VolW{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_UPD
    } seq_state_t;

    typedef struct packed {
        logic [VolW-1:0]   volume;
        logic [PriceW-1:0] close;
        logic [PriceW-1:0] low;
        logic [PriceW-1:0] high;
        logic [PriceW-1:0] open;
    } bar_t;

    // sequencer -> bar state
    typedef struct packed {
        logic              apply;
        logic [TimeW-1:0]  period;
        logic [PriceW-1:0] price;
        logic [SizeW-1:0]  size;
    } bar_cmd_t;

    // bar state -> sequencer
    typedef struct packed {
        logic is_new;
        logic started;
    } bar_stat_t;

endpackage

### design/ohlc_candle_aggregator_top.sv
// Top level: tick intake, sequencer, config register and bar output register.
//
//  channel | direction | handshake           | payload
//  s_*     | in        | s_tvalid/s_tready   | s_tdata: tick_time, tick_price, tick_size
//  m_*     | out       | m_tvalid/m_tready   | m_tdata: bar_open/high/low/close, bar_volume
//  cfg_*   | in        | cfg_valid/cfg_ready | cfg_data: frame_seconds
//
// An item is accepted, then its time goes through the bit-serial remainder unit
// (one time bit per cycle); the remainder is handed over and the bar is updated.
// A finished bar sits in the output register; the next item is accepted meanwhile
// and only the update step of a bar-closing item waits for that register to empty.
// Reset clears the bar state and sets frame_seconds to 60.
module ohlc_candle_aggregator_top
    import ohlc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [95:0]              s_tdata,   // tick_time, tick_price, tick_size
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [175:0]             m_tdata,   // bar_open, bar_high, bar_low, bar_close, bar_volume
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [FrameW-1:0]        cfg_data   // frame_seconds
);

    seq_state_t        state_reg, state_next;
    logic [FrameW-1:0] frame_reg;
    logic [TimeW-1:0]  time_reg;
    logic [PriceW-1:0] price_reg;
    logic [SizeW-1:0]  size_reg;
    logic              out_valid_reg;
    bar_t              out_bar_reg;

    logic              rem_start, rem_busy, rem_done;
    logic [FrameW-1:0] rem_val;
    logic [FrameW-1:0] divisor;
    logic              accept, stall, apply, emit;
    bar_cmd_t          cmd;
    bar_stat_t         stat;
    bar_t              cur;

    assign cfg_ready = 1'b1;
    assign divisor   = (frame_reg == '0) ? FrameW'(1) : frame_reg;
    assign accept    = s_tvalid & s_tready;
    assign emit      = stat.is_new & stat.started;
    // a closing bar waits while the previous one has not been taken
    assign stall     = emit & out_valid_reg & ~m_tready;

    ohlc_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (s_tdata[31:0]),
        .divisor  (divisor),
        .busy     (rem_busy),
        .done     (rem_done),
        .rem      (rem_val)
    );

    assign cmd.apply  = apply;
    assign cmd.period = time_reg - TimeW'(rem_val);
    assign cmd.price  = price_reg;
    assign cmd.size   = size_reg;

    ohlc_bar u_bar (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat),
        .cur   (cur)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = ST_DIV;
            ST_DIV:
                if (rem_done)
                    state_next = ST_UPD;
            ST_UPD:
                if (!stall)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready  = 1'b0;
        rem_start = 1'b0;
        apply     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready  = 1'b1;
                rem_start = s_tvalid;
            end
            ST_DIV:
                ;
            ST_UPD:
                apply = ~stall;
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            frame_reg     <= FrameReset;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                frame_reg <= cfg_data;
            if (apply && emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            time_reg  <= s_tdata[31:0];
            price_reg <= s_tdata[63:32];
            size_reg  <= s_tdata[95:64];
        end
        if (apply && emit)
            out_bar_reg <= cur;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_bar_reg;

    a_idle_unit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !rem_busy)
        else $error("remainder unit running while idle");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        rem_done |-> state_reg == ST_DIV)
        else $error("remainder done outside divide state");

    a_emit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        apply && emit |=> out_valid_reg)
        else $error("finished bar not presented");

endmodule

### design/ohlc_rem.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module ohlc_rem
    import ohlc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [TimeW-1:0]  dividend,
    input  logic [FrameW-1:0] divisor,
    output logic              busy,
    output logic              done,
    output logic [FrameW-1:0] rem
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [StepW-1:0]  cnt_reg, cnt_next;
    logic [TimeW-1:0]  dvd_reg, dvd_next;
    logic [FrameW-1:0] div_reg, div_next;
    logic [FrameW-1:0] rem_reg, rem_next;
    logic [FrameW:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[TimeW-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = StepW'(TimeW - 1);
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
                rem_next = FrameW'(trial - {1'b0, div_reg});
            else
                rem_next = trial[FrameW-1:0];
            dvd_next = {dvd_reg[TimeW-2:0], 1'b0};
            cnt_next = cnt_reg - StepW'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign rem  = rem_reg;

    // remainder is below the divisor when a run signals done
    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> rem_reg < div_reg)
        else $error("remainder not below divisor");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("done without a running division");

endmodule

### design/ohlc_bar.sv
// Bar in progress: period tracking and open/high/low/close/volume update.
module ohlc_bar
    import ohlc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  bar_cmd_t  cmd,
    output bar_stat_t stat,
    output bar_t      cur
);

    logic [TimeW-1:0] last_reg, last_next;
    logic             started_reg, started_next;
    bar_t             bar_reg, bar_next;
    logic             is_new;
    logic [VolW:0]    vol_sum;

    assign is_new  = cmd.period > last_reg;
    assign vol_sum = {1'b0, bar_reg.volume} + (VolW+1)'(cmd.size);

    always_comb
    begin
        last_next    = last_reg;
        started_next = started_reg;
        bar_next     = bar_reg;
        if (cmd.apply)
        begin
            if (is_new)
            begin
                last_next       = cmd.period;
                started_next    = 1'b1;
                bar_next.open   = cmd.price;
                bar_next.high   = cmd.price;
                bar_next.low    = cmd.price;
                bar_next.close  = cmd.price;
                bar_next.volume = VolW'(cmd.size);
            end
            else
            begin
                bar_next.close = cmd.price;
                if (cmd.price < bar_reg.low)
                    bar_next.low = cmd.price;
                else if (cmd.price > bar_reg.high)
                    bar_next.high = cmd.price;
                bar_next.volume = vol_sum[VolW] ? VolMax : vol_sum[VolW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg    <= '0;
            started_reg <= 1'b0;
            bar_reg     <= '0;
        end
        else
        begin
            last_reg    <= last_next;
            started_reg <= started_next;
            bar_reg     <= bar_next;
        end
    end

    assign stat.is_new  = is_new;
    assign stat.started = started_reg;
    assign cur          = bar_reg;

    a_started_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(started_reg) |-> started_reg)
        else $error("started flag cleared");

endmodule

### dv/tb_top.sv
// Testbench for the OHLC candle aggregator: directed table, wide volume run, random phases.
module tb_top;
    import ohlc_pkg::*;

    localparam int      HoldCycles = 600;
    localparam int      DrainWait  = 40;
    localparam longint  CycleLimit = 1_000_000;

    typedef enum logic [1:0] {
        ROW_PRED,
        ROW_QUIET,
        ROW_BAR
    } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [31:0] t;
        logic [31:0] p;
        logic [31:0] s;
        bar_t        bar;
    } tick_row_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [95:0]         s_tdata;   // tick_time, tick_price, tick_size
    logic                m_tvalid;
    logic                m_tready;
    logic [175:0]        m_tdata;   // bar_open, bar_high, bar_low, bar_close, bar_volume
    logic                cfg_valid;
    logic                cfg_ready;
    logic [FrameW-1:0]   cfg_data;  // frame_seconds

    // bar predictor state
    logic [FrameW-1:0]   frame_cfg;
    logic [31:0]         last_start;
    bit                  bar_started;
    bar_t                live_bar;
    bar_t                pending_bars[$];

    bit                  quiet;
    bit                  hold_req;
    int                  err_cnt;
    longint              cycles;

    ohlc_candle_aggregator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic report_miss(input string msg);
        if (err_cnt < 50)
            $display("%s", msg);
        err_cnt++;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_miss($sformatf("bar %s: got %h, want %h", what, got, want));
    endtask

    // Folds one accepted tick into the running bar; queues the finished bar if one closes and keep is set.
    function automatic void fold_tick(input logic [31:0] t, input logic [31:0] p,
                                      input logic [31:0] s, input bit keep);
        logic [31:0]   fr;
        logic [31:0]   per;
        logic [VolW:0] sum;
        fr  = (frame_cfg == '0) ? 32'd1 : 32'(frame_cfg);
        per = t - (t % fr);
        if (per > last_start)
        begin
            last_start = per;
            if (bar_started)
            begin
                if (keep)
                    pending_bars.push_back(live_bar);
            end
            else
            begin
                bar_started = 1'b1;
            end
            live_bar.open   = p;
            live_bar.high   = p;
            live_bar.low    = p;
            live_bar.close  = p;
            live_bar.volume = VolW'(s);
        end
        else
        begin
            live_bar.close = p;
            if (p < live_bar.low)
                live_bar.low = p;
            else if (p > live_bar.high)
                live_bar.high = p;
            sum = {1'b0, live_bar.volume} + (VolW+1)'(s);
            live_bar.volume = sum[VolW] ? VolMax : sum[VolW-1:0];
        end
    endfunction

    task automatic send_tick(input logic [31:0] t, input logic [31:0] p,
                             input logic [31:0] s, input bit keep);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= {s, p, t};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        fold_tick(t, p, s, keep);
    endtask

    // Let the block go idle; ticks that close nothing may still be in the remainder unit.
    task automatic drain_bars();
        s_tvalid <= 1'b0;
        while (pending_bars.size() != 0)
            @(posedge clk);
        repeat (DrainWait) @(posedge clk);
    endtask

    task automatic write_frame(input logic [FrameW-1:0] f);
        cfg_data  <= f;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        frame_cfg = f;
    endtask

    // bar sink: random back-pressure plus one long hold-off on request
    initial
    begin : bar_sink
        int n;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                n = $urandom_range(1, 8);
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else
            begin
                n = quiet ? 1 : $urandom_range(1, 24);
                m_tready <= 1'b1;
                repeat (n) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        bar_t got;
        bar_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_bars.size() == 0)
            begin
                report_miss($sformatf("unexpected bar: %h", m_tdata));
            end
            else
            begin
                want = pending_bars.pop_front();
                check_field("open",   64'(got.open),   64'(want.open));
                check_field("high",   64'(got.high),   64'(want.high));
                check_field("low",    64'(got.low),    64'(want.low));
                check_field("close",  64'(got.close),  64'(want.close));
                check_field("volume", 64'(got.volume), 64'(want.volume));
            end
        end
    end

    initial
    begin : stimulus
        tick_row_t         rows[$];
        logic [FrameW-1:0] plan[7];
        logic [31:0]       cursor;
        logic [31:0]       fr;
        logic [31:0]       t;
        logic [31:0]       p;
        logic [31:0]       s;
        logic [31:0]       back;
        int                r;

        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        quiet       = 1'b0;
        hold_req    = 1'b0;
        err_cnt     = 0;
        cycles      = 0;
        frame_cfg   = FrameReset;
        last_start  = '0;
        bar_started = 1'b0;
        live_bar    = '0;

        // reset frame of 60 s; bar_t literal order is volume, close, low, high, open
        rows.push_back('{ROW_QUIET, 32'd0,   32'd100,       32'd5,         '0});
        rows.push_back('{ROW_QUIET, 32'd59,  32'd0,         32'hFFFF_FFFF, '0});
        rows.push_back('{ROW_QUIET, 32'd60,  32'd200,       32'd1,         '0});
        rows.push_back('{ROW_QUIET, 32'd119, 32'hFFFF_FFFF, 32'd2,         '0});
        rows.push_back('{ROW_QUIET, 32'd30,  32'd0,         32'd3,         '0});
        rows.push_back('{ROW_BAR,   32'd120, 32'd500,       32'd7,
                         bar_t'{48'd6, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd200}});
        rows.push_back('{ROW_QUIET, 32'd125, 32'd400,       32'd0,         '0});
        rows.push_back('{ROW_QUIET, 32'd179, 32'd600,       32'hFFFF_FFFF, '0});
        rows.push_back('{ROW_BAR,   32'd180, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         bar_t'{48'h1_0000_0006, 32'd600, 32'd400, 32'd600, 32'd500}});
        rows.push_back('{ROW_QUIET, 32'd0,   32'd0,         32'd0,         '0});
        rows.push_back('{ROW_BAR,   32'd240, 32'd0,         32'd0,
                         bar_t'{48'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}});
        rows.push_back('{ROW_QUIET, 32'd241, 32'd1,         32'd1,         '0});
        rows.push_back('{ROW_PRED,  32'd305, 32'h8000_0000, 32'h1234_5678, '0});
        rows.push_back('{ROW_PRED,  32'd359, 32'h7FFF_FFFF, 32'h8000_0000, '0});
        rows.push_back('{ROW_PRED,  32'd301, 32'h5555_5555, 32'hAAAA_AAAA, '0});
        rows.push_back('{ROW_PRED,  32'd420, 32'hAAAA_AAAA, 32'h5555_5555, '0});
        rows.push_back('{ROW_PRED,  32'd1000, 32'h0000_FFFF, 32'hFFFF_0000, '0});
        rows.push_back('{ROW_PRED,  32'd1019, 32'hFFFF_0000, 32'd9,        '0});

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            send_tick(rows[i].t, rows[i].p, rows[i].s, rows[i].kind == ROW_PRED);
            if (rows[i].kind == ROW_BAR)
                pending_bars.push_back(rows[i].bar);
        end

        // one period of full-size ticks, carrying the volume well past 32 bits
        send_tick(32'd1500, $urandom, 32'hFFFF_FFFF, 1'b1);
        repeat (48)
            send_tick(32'd1500 + $urandom_range(0, 59), $urandom, 32'hFFFF_FFFF, 1'b1);
        send_tick(32'd1560, $urandom, $urandom, 1'b1);

        plan[0] = FrameW'(1);
        plan[1] = FrameW'(0);
        plan[2] = FrameW'(86400);
        plan[3] = {FrameW{1'b1}};
        plan[4] = FrameW'(7);
        plan[5] = FrameW'($urandom_range(2, 3600));
        plan[6] = FrameW'(60);
        cursor  = 32'd2000;

        foreach (plan[ph])
        begin
            drain_bars();
            write_frame(plan[ph]);
            quiet  = (ph == 6);
            fr     = (plan[ph] == '0) ? 32'd1 : 32'(plan[ph]);
            cursor = cursor + $urandom_range(1, 32'h2000_0000);
            for (int n = 0; n < 268; n++)
            begin
                if (ph == 0 && n == 20)
                    hold_req = 1'b1;
                r = $urandom_range(0, 99);
                if (r < 30)
                begin
                    cursor = cursor + $urandom_range(1, 2 * fr);
                    t = cursor;
                end
                else if (r < 80)
                begin
                    t = cursor + $urandom_range(0, 2);
                end
                else if (r < 92)
                begin
                    // late tick, possibly from an earlier period
                    back = $urandom_range(0, 3 * fr);
                    t = (cursor >= back) ? cursor - back : 32'd0;
                end
                else
                begin
                    t = $urandom_range(0, cursor);
                end
                r = $urandom_range(0, 9);
                p = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
                r = $urandom_range(0, 9);
                s = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF :
                    (r < 6) ? $urandom_range(0, 1000) : $urandom;
                send_tick(t, p, s, 1'b1);
            end
        end

        // top of the time range: closes the last bar, then updates the new one
        send_tick(32'hFFFF_FFFF, 32'd0,         32'd0,         1'b1);
        send_tick(32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_tick(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1);
        drain_bars();

        if (err_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
